// ===== rtl/sbus_frame_receiver_top_assert.svh =====
// Assertion macros for the SBUS frame receiver.
`ifndef SBUS_FRAME_RECEIVER_TOP_ASSERT_SVH
`define SBUS_FRAME_RECEIVER_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define SFR_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("SBUS frame receiver assertion failed");
`define SFR_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("SBUS frame receiver assertion failed");
`else
`define SFR_ASSERT_SAME(lbl, clk, rst, ante, cons)
`define SFR_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

// ===== rtl/sfr_pkg.sv =====
// Shared types, constants and helpers of the SBUS frame receiver.
`default_nettype none
package sfr_pkg;
   localparam int FRAME_LEN   = 25;
   localparam int CHAN_COUNT  = 16;
   localparam int CHAN_BITS   = 11;
   localparam int CHAN_BYTES  = 22;
   localparam int STATUS_POS  = 23;
   localparam int CHAN_DATA_W = CHAN_COUNT * CHAN_BITS;
   localparam int FILL_W      = $clog2(FRAME_LEN + 1);
   localparam int PROD_W      = CHAN_BITS + 16;
   localparam int LOST_BIT     = 2;
   localparam int FAILSAFE_BIT = 3;

   localparam logic [7:0]  START_BYTE     = 8'h0F;
   localparam logic [7:0]  PLAIN_FOOTER   = 8'h00;
   localparam logic [3:0]  VARIANT_NIBBLE = 4'h4;
   localparam logic [10:0] RAW_MAX        = 11'd2047;
   localparam logic [10:0] ROUND_BIAS     = 11'd1023;

   localparam logic [7:0] CSR_FOOTER_VARIANT = 8'd0;
   localparam logic [7:0] CSR_OUTPUT_SCALE   = 8'd1;

   typedef enum logic [1:0] {
      FS_COLLECT,
      FS_REALIGN,
      FS_PUSH
   } front_state_type;

   typedef struct packed {
      logic [CHAN_DATA_W-1:0] chan_data;
      logic                   lost;
      logic                   failsafe;
      logic [31:0]            bad_total;
   } frame_entry_type;

   typedef struct packed {
      logic [3:0]  index;
      logic        lost;
      logic        failsafe;
      logic [31:0] bad_total;
      logic        last;
   } chan_meta_type;

   // Divides by 2047 = 2^11 - 1 through two folds of the top bits onto the bottom,
   // followed by a single compare-and-correct step.
   function automatic logic [15:0] div_raw_max(input logic [PROD_W-1:0] x);
      logic [15:0] q0;
      logic [16:0] r1;
      logic [5:0]  q1;
      logic [11:0] r2;
      logic        c;
      q0 = x[PROD_W-1:11];
      r1 = {6'd0, x[10:0]} + {1'b0, q0};
      q1 = r1[16:11];
      r2 = {1'b0, r1[10:0]} + {6'd0, q1};
      c  = (r2 >= {1'b0, RAW_MAX});
      return q0 + {10'd0, q1} + {15'd0, c};
   endfunction
endpackage
`default_nettype wire

// ===== rtl/sfr_front.sv =====
// Front end: collects bytes into a frame, checks it and realigns after a bad frame.
`default_nettype none
module sfr_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  logic [7:0]             rx_byte,
   output logic                   full,
   input  logic                   accept_variant,
   output sfr_pkg::frame_entry_type entry,
   output logic                   entry_valid,
   input  logic                   entry_ready
);
   import sfr_pkg::*;

   front_state_type   state_ff, state_in;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic [31:0]       rejected_ff, rejected_in;
   logic [7:0]        frame_ff [FRAME_LEN];
   logic [7:0]        frame_in [FRAME_LEN];
   logic              accept;
   logic              footer_ok;

   assign accept = push && (state_ff == FS_COLLECT);
   assign footer_ok = (frame_ff[0] == START_BYTE) &&
                      ((rx_byte == PLAIN_FOOTER) ||
                       (accept_variant && (rx_byte[3:0] == VARIANT_NIBBLE)));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= FS_COLLECT;
         fill_ff     <= '0;
         rejected_ff <= '0;
      end else begin
         state_ff    <= state_in;
         fill_ff     <= fill_in;
         rejected_ff <= rejected_in;
      end
   end

   always_ff @(posedge clock) begin
      frame_ff <= frame_in;
   end

   always_comb begin
      state_in    = state_ff;
      fill_in     = fill_ff;
      rejected_in = rejected_ff;
      frame_in    = frame_ff;
      case (state_ff)
         FS_COLLECT: begin
            if (accept) begin
               if (fill_ff == '0) begin
                  if (rx_byte == START_BYTE) begin
                     frame_in[0] = rx_byte;
                     fill_in     = FILL_W'(1);
                  end
               end else begin
                  frame_in[fill_ff] = rx_byte;
                  if (fill_ff == FILL_W'(FRAME_LEN - 1)) begin
                     if (footer_ok) begin
                        fill_in  = '0;
                        state_in = FS_PUSH;
                     end else begin
                        if (rejected_ff != '1) begin
                           rejected_in = rejected_ff + 32'd1;
                        end
                        fill_in  = FILL_W'(FRAME_LEN);
                        state_in = FS_REALIGN;
                     end
                  end else begin
                     fill_in = fill_ff + FILL_W'(1);
                  end
               end
            end
         end
         FS_REALIGN: begin
            // One byte drops off the front each cycle until a start byte leads
            // the buffer or nothing is left.
            for (int i = 0; i < FRAME_LEN - 1; i++) begin
               frame_in[i] = frame_ff[i+1];
            end
            fill_in = fill_ff - FILL_W'(1);
            if ((frame_ff[1] == START_BYTE) || (fill_ff == FILL_W'(1))) begin
               state_in = FS_COLLECT;
            end
         end
         FS_PUSH: begin
            if (entry_ready) begin
               state_in = FS_COLLECT;
            end
         end
         default: begin
            state_in = FS_COLLECT;
            fill_in  = '0;
         end
      endcase
   end

   always_comb begin
      for (int i = 0; i < CHAN_BYTES; i++) begin
         entry.chan_data[8*i +: 8] = frame_ff[i+1];
      end
      entry.lost      = frame_ff[STATUS_POS][LOST_BIT];
      entry.failsafe  = frame_ff[STATUS_POS][FAILSAFE_BIT];
      entry.bad_total = rejected_ff;
   end

   assign full        = (state_ff != FS_COLLECT);
   assign entry_valid = (state_ff == FS_PUSH);
endmodule
`default_nettype wire

// ===== rtl/sfr_queue.sv =====
// Short queue of accepted frames between the front and back ends.
`default_nettype none
module sfr_queue #(
   parameter int DEPTH = 2
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     wr_valid,
   output logic                     wr_ready,
   input  sfr_pkg::frame_entry_type wr_data,
   output logic                     rd_valid,
   input  logic                     rd_pop,
   output sfr_pkg::frame_entry_type rd_data
);
   import sfr_pkg::*;

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   frame_entry_type  slots_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_wr;
   logic             do_rd;

   assign wr_ready = (count_ff != CNT_W'(DEPTH));
   assign rd_valid = (count_ff != '0);
   assign do_wr    = wr_valid && wr_ready;
   assign do_rd    = rd_pop && rd_valid;
   assign rd_data  = slots_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_wr && !do_rd) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         slots_ff[wr_ptr_ff] <= wr_data;
      end
   end
endmodule
`default_nettype wire

// ===== rtl/sfr_back.sv =====
// Back end: unpacks the sixteen channels of a frame and scales each one.
`default_nettype none
module sfr_back (
   input  logic                     clock,
   input  logic                     reset,
   input  sfr_pkg::frame_entry_type entry,
   input  logic                     entry_valid,
   output logic                     entry_pop,
   input  logic [15:0]              output_scale,
   output logic                     rsp_empty,
   input  logic                     rsp_pop,
   output logic [3:0]               rsp_channel_index,
   output logic [15:0]              rsp_channel_value,
   output logic                     rsp_frame_lost,
   output logic                     rsp_failsafe,
   output logic [31:0]              rsp_bad_frame_total,
   output logic                     rsp_last
);
   import sfr_pkg::*;

   // Channel sequencer.
   logic                   busy_ff, busy_in;
   logic [CHAN_DATA_W-1:0] data_ff, data_in;
   logic [3:0]             cnt_ff, cnt_in;
   logic                   lost_ff, failsafe_ff;
   logic [31:0]            total_ff;
   // Multiply stage.
   logic                   mul_valid_ff, mul_valid_in;
   logic [PROD_W-1:0]      mul_prod_ff;
   chan_meta_type          mul_meta_ff;
   // Result register.
   logic                   out_valid_ff, out_valid_in;
   logic [15:0]            out_value_ff;
   chan_meta_type          out_meta_ff;

   logic                   out_load;
   logic                   mul_adv;
   logic                   issue;
   logic [CHAN_BITS-1:0]   raw;
   logic [PROD_W-1:0]      rounded;

   assign out_load  = mul_valid_ff && (!out_valid_ff || rsp_pop);
   assign mul_adv   = !mul_valid_ff || out_load;
   assign issue     = busy_ff && mul_adv;
   assign entry_pop = !busy_ff && entry_valid;
   assign raw       = data_ff[CHAN_BITS-1:0];
   assign rounded   = mul_prod_ff + PROD_W'(ROUND_BIAS);

   always_comb begin
      busy_in      = busy_ff;
      data_in      = data_ff;
      cnt_in       = cnt_ff;
      mul_valid_in = mul_valid_ff;
      out_valid_in = out_valid_ff;
      if (entry_pop) begin
         busy_in = 1'b1;
         data_in = entry.chan_data;
         cnt_in  = '0;
      end else if (issue) begin
         data_in = data_ff >> CHAN_BITS;
         cnt_in  = cnt_ff + 4'd1;
         if (cnt_ff == 4'(CHAN_COUNT - 1)) begin
            busy_in = 1'b0;
         end
      end
      if (mul_adv) begin
         mul_valid_in = issue;
      end
      if (out_load) begin
         out_valid_in = 1'b1;
      end else if (rsp_pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         mul_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
         cnt_ff       <= '0;
      end else begin
         busy_ff      <= busy_in;
         mul_valid_ff <= mul_valid_in;
         out_valid_ff <= out_valid_in;
         cnt_ff       <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
      if (entry_pop) begin
         lost_ff     <= entry.lost;
         failsafe_ff <= entry.failsafe;
         total_ff    <= entry.bad_total;
      end
      if (issue) begin
         mul_prod_ff          <= PROD_W'(raw) * PROD_W'(output_scale);
         mul_meta_ff.index    <= cnt_ff;
         mul_meta_ff.lost     <= lost_ff;
         mul_meta_ff.failsafe <= failsafe_ff;
         mul_meta_ff.bad_total <= total_ff;
         mul_meta_ff.last     <= (cnt_ff == 4'(CHAN_COUNT - 1));
      end
      if (out_load) begin
         out_value_ff <= div_raw_max(rounded);
         out_meta_ff  <= mul_meta_ff;
      end
   end

   assign rsp_empty           = !out_valid_ff;
   assign rsp_channel_index   = out_meta_ff.index;
   assign rsp_channel_value   = out_value_ff;
   assign rsp_frame_lost      = out_meta_ff.lost;
   assign rsp_failsafe        = out_meta_ff.failsafe;
   assign rsp_bad_frame_total = out_meta_ff.bad_total;
   assign rsp_last            = out_meta_ff.last;
endmodule
`default_nettype wire

// ===== rtl/sbus_frame_receiver_top.sv =====
// Top level of the SBUS frame receiver: front end, frame queue and channel back end.
// Usage:
// Bytes from the serial line enter on req_rx_byte, one transaction per byte, taken at a
// clock edge with req_push high and req_full low. Channel results leave on the rsp_
// ports while rsp_empty is low; rsp_pop takes one. Each good frame gives sixteen results
// in channel order, the sixteenth marked by rsp_last.
// A byte that does not complete a frame leaves req_full low. After the footer byte of
// a good frame req_full is high until the frame moves into the queue; the first channel
// result then passes the channel sequencer, the multiply stage and the result register,
// and results follow one per cycle while rsp_pop keeps up. A rejected frame raises
// req_full while the buffer shifts one byte a cycle to the next start byte.
// If the receiver stops popping, results wait in the output register, frames wait in
// the queue (QUEUE_DEPTH frames) and finally req_full rises; nothing is dropped.
// Configuration writes on the csr_ channel are always taken and must only be made
// while the block is idle. Reset empties the queue, clears the rejected-frame count,
// returns to hunting for a start byte and restores the register defaults.
`default_nettype none
module sbus_frame_receiver_top #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [3:0]  rsp_channel_index,
   output logic [15:0] rsp_channel_value,
   output logic        rsp_frame_lost,
   output logic        rsp_failsafe,
   output logic [31:0] rsp_bad_frame_total,
   output logic        rsp_last,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_index,
   input  logic [15:0] csr_wdata
);
   import sfr_pkg::*;

   `include "sbus_frame_receiver_top_assert.svh"

   logic            variant_ff;
   logic [15:0]     scale_ff;
   frame_entry_type front_entry;
   logic            front_valid;
   logic            front_ready;
   frame_entry_type queue_entry;
   logic            queue_valid;
   logic            queue_pop;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         variant_ff <= 1'b1;
         scale_ff   <= 16'd2047;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_FOOTER_VARIANT: variant_ff <= csr_wdata[0];
            CSR_OUTPUT_SCALE:   scale_ff   <= csr_wdata;
            default:            ;
         endcase
      end
   end

   sfr_front u_front (
      .clock          (clock),
      .reset          (reset),
      .push           (req_push),
      .rx_byte        (req_rx_byte),
      .full           (req_full),
      .accept_variant (variant_ff),
      .entry          (front_entry),
      .entry_valid    (front_valid),
      .entry_ready    (front_ready)
   );

   sfr_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (front_valid),
      .wr_ready (front_ready),
      .wr_data  (front_entry),
      .rd_valid (queue_valid),
      .rd_pop   (queue_pop),
      .rd_data  (queue_entry)
   );

   sfr_back u_back (
      .clock               (clock),
      .reset               (reset),
      .entry               (queue_entry),
      .entry_valid         (queue_valid),
      .entry_pop           (queue_pop),
      .output_scale        (scale_ff),
      .rsp_empty           (rsp_empty),
      .rsp_pop             (rsp_pop),
      .rsp_channel_index   (rsp_channel_index),
      .rsp_channel_value   (rsp_channel_value),
      .rsp_frame_lost      (rsp_frame_lost),
      .rsp_failsafe        (rsp_failsafe),
      .rsp_bad_frame_total (rsp_bad_frame_total),
      .rsp_last            (rsp_last)
   );

   // Nothing is on offer straight after reset.
   `SFR_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, rsp_empty)
   // Only the sixteenth channel of a frame carries the last marker.
   `SFR_ASSERT_SAME(a_last_is_final, clock, reset, !rsp_empty && rsp_last,
                    rsp_channel_index == 4'd15)
   // Within a frame, the channel after a popped one is the next in order.
   `SFR_ASSERT_NEXT(a_channel_order, clock, reset, !rsp_empty && rsp_pop && !rsp_last,
                    rsp_empty || (rsp_channel_index == $past(rsp_channel_index) + 4'd1))
endmodule
`default_nettype wire
